// File: hw/rtl/edsim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edsim_pkg
// Shared types, constants and helpers for the edit-distance similarity block.
// ----------------------------------------------------------------------------
package edsim_pkg;

	localparam int MAX_QUERY_DEF = 64;
	localparam int COST_W        = 16;
	localparam int SIM_W         = 17;
	localparam int CHAR_W        = 8;
	localparam int DIV_STEPS     = 16;
	localparam int DIV_CNT_W     = 5;

	localparam logic [COST_W-1:0] CAND_MAX     = 16'hFFFF;
	localparam logic [SIM_W-1:0]  Q16_ONE      = 17'h10000;
	localparam logic [SIM_W-1:0]  THRESH_RESET = 17'd39322;

	// register index, taken from paddr[2]
	localparam logic REG_MATCH_THRESHOLD = 1'b0;

	typedef enum logic [1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_CHAR   = 2'd2,
		REQ_END    = 2'd3
	} req_t;

	// one wavefront travelling along the row of cells
	typedef struct packed {
		logic              valid;
		logic              mark;   // end-of-candidate marker
		logic [CHAR_W-1:0] ch;
		logic [COST_W-1:0] left;   // new cost of the cell to the left
		logic [COST_W-1:0] diag;   // old cost of the cell to the left
	} edsim_wave_t;

	// row-wide control
	typedef struct packed {
		logic              restart; // reload costs, drop waves in flight
		logic              clear;   // forget the query
		logic              load;    // append a query character
		logic [CHAR_W-1:0] ch;
	} edsim_ctl_t;

	function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/edit_distance_name_similarity.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edit_distance_name_similarity
// Levenshtein distance and Q16 similarity of candidate names against a query.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid / in_stall, req_type, char_code): one request per
//  transfer - clear query, append query character, candidate character, end
//  of candidate. Letters A-Z are folded to lower case on entry.
//  Clear, append and candidate characters do not raise in_stall themselves;
//  characters of a candidate stream back to back through the row of MAX_QUERY
//  cells. An end request holds in_stall high while the end marker walks the
//  row (its leaving the row also settles the case), while the divider, if a
//  division is due, forms the 16 quotient bits one a cycle and then takes the
//  quotient, and until the result is loaded into the output register.
//  Output channel (out_valid / out_stall, distance, similarity,
//  above_threshold, truncated): one transfer per end request. The output
//  register lets new requests in while a result waits; a result that finds
//  the register still held keeps the block stalled until out_stall drops.
//  APB port: match_threshold at byte address 0, pready always high.
//  Reset empties the query, reloads the cost row and sets the threshold to
//  39322 (about 0.6).
// ----------------------------------------------------------------------------
module edit_distance_name_similarity #(
	parameter int MAX_QUERY = edsim_pkg::MAX_QUERY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  char_code,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] distance,
	output logic [16:0] similarity,
	output logic        above_threshold,
	output logic        truncated,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int QLW = $clog2(MAX_QUERY + 1);
	localparam int CW  = edsim_pkg::COST_W;
	localparam int SW  = edsim_pkg::SIM_W;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DRAIN = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_HOLD  = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [QLW-1:0]         qlen_q;
	logic [CW-1:0]          cand_q;
	logic                   ovf_q;
	logic [SW-1:0]          thr_q;
	logic [CW-1:0]          last_q;

	// wave injected at the head of the row
	logic                        inj_valid_q;
	logic                        inj_mark_q;
	logic [edsim_pkg::CHAR_W-1:0] inj_ch_q;
	logic [CW-1:0]               inj_left_q;
	logic [CW-1:0]               inj_diag_q;

	logic [CW-1:0] res_dist_q;
	logic [SW-1:0] res_sim_q;
	logic          res_trunc_q;

	logic          out_valid_q;
	logic [CW-1:0] out_dist_q;
	logic [SW-1:0] out_sim_q;
	logic          out_above_q;
	logic          out_trunc_q;

	edsim_pkg::edsim_ctl_t  ctl;
	edsim_pkg::edsim_wave_t inj;
	edsim_pkg::edsim_wave_t chain_out;
	edsim_pkg::req_t        req;
	logic [7:0]             ch_fold;
	logic                   acc, room, cand_room, drain_done, out_free;
	logic [CW-1:0]          qlen_w, max_len, dist_c;
	logic                   div_start, div_busy, div_done;
	logic [CW-1:0]          div_quo;

	// ---- input side ----
	assign in_stall  = (state_q != ST_IDLE);
	assign acc       = in_valid && !in_stall;
	assign req       = edsim_pkg::req_t'(req_type);
	assign ch_fold   = edsim_pkg::fold_case(char_code);
	assign room      = qlen_q < QLW'(MAX_QUERY);
	assign cand_room = cand_q < edsim_pkg::CAND_MAX;

	// end marker leaving the last cell: every candidate wave has been folded in
	assign drain_done = (state_q == ST_DRAIN) && chain_out.valid && chain_out.mark;

	always_comb begin
		ctl.restart = (acc && (req == edsim_pkg::REQ_CLEAR || req == edsim_pkg::REQ_APPEND))
			|| drain_done;
		ctl.clear   = acc && (req == edsim_pkg::REQ_CLEAR);
		ctl.load    = acc && (req == edsim_pkg::REQ_APPEND) && room;
		ctl.ch      = ch_fold;
	end

	always_comb begin
		inj.valid = inj_valid_q;
		inj.mark  = inj_mark_q;
		inj.ch    = inj_ch_q;
		inj.left  = inj_left_q;
		inj.diag  = inj_diag_q;
	end

	edsim_chain #(
		.MAX_QUERY (MAX_QUERY),
		.QLW       (QLW)
	) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.load_idx (qlen_q),
		.wave_in  (inj),
		.wave_out (chain_out)
	);

	// ---- end-of-candidate decision ----
	always_comb begin
		qlen_w  = CW'(qlen_q);
		max_len = (qlen_w > cand_q) ? qlen_w : cand_q;
		dist_c  = (last_q > max_len) ? max_len : last_q;
	end

	assign div_start = drain_done && (qlen_q != '0) && (cand_q != '0) && (dist_c != '0);

	edsim_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (max_len - dist_c),
		.den    (max_len),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign out_free = !out_valid_q || !out_stall;

	// ---- control ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			qlen_q      <= '0;
			cand_q      <= '0;
			ovf_q       <= 1'b0;
			thr_q       <= edsim_pkg::THRESH_RESET;
			inj_valid_q <= 1'b0;
			inj_mark_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && pready
				&& paddr[2] == edsim_pkg::REG_MATCH_THRESHOLD) begin
				thr_q <= pwdata[SW-1:0];
			end

			// output register: load a held result, or empty once taken
			if (state_q == ST_HOLD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end

			inj_valid_q <= acc && ((req == edsim_pkg::REQ_CHAR && cand_room)
				|| req == edsim_pkg::REQ_END);
			inj_mark_q  <= acc && (req == edsim_pkg::REQ_END);

			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						unique case (req)
							edsim_pkg::REQ_CLEAR: begin
								qlen_q <= '0;
								ovf_q  <= 1'b0;
								cand_q <= '0;
							end
							edsim_pkg::REQ_APPEND: begin
								if (room) begin
									qlen_q <= qlen_q + 1'b1;
								end else begin
									ovf_q <= 1'b1;
								end
								cand_q <= '0;
							end
							edsim_pkg::REQ_CHAR: begin
								if (cand_room) begin
									cand_q <= cand_q + 1'b1;
								end
							end
							edsim_pkg::REQ_END: begin
								state_q <= ST_DRAIN;
							end
							default: ;
						endcase
					end
				end
				ST_DRAIN: begin
					if (drain_done) begin
						cand_q  <= '0;
						state_q <= div_start ? ST_DIV : ST_HOLD;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---- payload ----
	always_ff @(posedge clk) begin
		inj_ch_q   <= ch_fold;
		inj_left_q <= cand_q + 1'b1;
		inj_diag_q <= cand_q;

		// latest cost to leave the row is the bottom-right entry
		if (chain_out.valid && !chain_out.mark) begin
			last_q <= chain_out.left;
		end

		if (drain_done) begin
			res_trunc_q <= ovf_q || (cand_q == edsim_pkg::CAND_MAX);
			if (qlen_q == '0) begin
				res_dist_q <= cand_q;
				res_sim_q  <= (cand_q == '0) ? edsim_pkg::Q16_ONE : '0;
			end else if (cand_q == '0) begin
				res_dist_q <= qlen_w;
				res_sim_q  <= '0;
			end else begin
				res_dist_q <= dist_c;
				res_sim_q  <= (dist_c == '0) ? edsim_pkg::Q16_ONE : '0;
			end
		end else if (div_done) begin
			res_sim_q <= SW'(div_quo);
		end

		if (state_q == ST_HOLD && out_free) begin
			out_dist_q  <= res_dist_q;
			out_sim_q   <= res_sim_q;
			out_above_q <= res_sim_q > thr_q;
			out_trunc_q <= res_trunc_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign distance        = out_dist_q;
	assign similarity      = out_sim_q;
	assign above_threshold = out_above_q;
	assign truncated       = out_trunc_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == edsim_pkg::REG_MATCH_THRESHOLD) ? 32'(thr_q) : '0;

	// ---- assertions ----
	a_marker_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(chain_out.valid && chain_out.mark) |-> (state_q == ST_DRAIN))
		else $error("end marker left the row outside drain");

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == ST_DIV))
		else $error("divider running outside divide state");

	a_sim_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_sim_q <= edsim_pkg::Q16_ONE))
		else $error("similarity above one");

	a_qlen_range: assert property (@(posedge clk) disable iff (!arst_n)
		qlen_q <= QLW'(MAX_QUERY))
		else $error("query length beyond row size");

endmodule

// File: hw/rtl/edsim_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edsim_cell
// One query position: holds its character and cost, updates its cost on each candidate character while active.
// ----------------------------------------------------------------------------
module edsim_cell #(
	parameter int INDEX = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  edsim_pkg::edsim_ctl_t  ctl,
	input  edsim_pkg::edsim_wave_t wave_in,
	output edsim_pkg::edsim_wave_t wave_out
);

	localparam logic [edsim_pkg::COST_W-1:0] INIT_COST = edsim_pkg::COST_W'(INDEX + 1);

	logic [edsim_pkg::CHAR_W-1:0] char_q;
	logic                         active_q;
	logic [edsim_pkg::COST_W-1:0] cost_q;

	logic                         valid_q;
	logic                         mark_q;
	logic [edsim_pkg::CHAR_W-1:0] ch_q;
	logic [edsim_pkg::COST_W-1:0] left_q;
	logic [edsim_pkg::COST_W-1:0] diag_q;

	logic [edsim_pkg::COST_W:0]   up_p1, left_p1, sub, m1, v17;
	logic [edsim_pkg::COST_W-1:0] v;

	always_comb begin
		up_p1   = {1'b0, cost_q} + 1'b1;
		left_p1 = {1'b0, wave_in.left} + 1'b1;
		sub     = {1'b0, wave_in.diag} + ((char_q == wave_in.ch) ? 1'b0 : 1'b1);
		m1      = (up_p1 < left_p1) ? up_p1 : left_p1;
		v17     = (m1 < sub) ? m1 : sub;
		v       = v17[edsim_pkg::COST_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cost_q   <= INIT_COST;
			valid_q  <= 1'b0;
			mark_q   <= 1'b0;
		end else begin
			if (ctl.clear) begin
				active_q <= 1'b0;
			end else if (ctl.load) begin
				active_q <= 1'b1;
			end
			if (ctl.restart) begin
				cost_q  <= INIT_COST;
				valid_q <= 1'b0;
				mark_q  <= 1'b0;
			end else begin
				valid_q <= wave_in.valid;
				mark_q  <= wave_in.mark;
				if (wave_in.valid && !wave_in.mark && active_q) begin
					cost_q <= v;
				end
			end
		end
	end

	// payload, no reset; inactive cells pass the wave straight on
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			char_q <= ctl.ch;
		end
		ch_q   <= wave_in.ch;
		left_q <= active_q ? v : wave_in.left;
		diag_q <= active_q ? cost_q : wave_in.diag;
	end

	always_comb begin
		wave_out.valid = valid_q;
		wave_out.mark  = mark_q;
		wave_out.ch    = ch_q;
		wave_out.left  = left_q;
		wave_out.diag  = diag_q;
	end

endmodule

// File: hw/rtl/edsim_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edsim_chain
// Row of query cells; waves enter at cell 0 and leave after the last cell.
// ----------------------------------------------------------------------------
module edsim_chain #(
	parameter int MAX_QUERY = edsim_pkg::MAX_QUERY_DEF,
	parameter int QLW       = $clog2(MAX_QUERY + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  edsim_pkg::edsim_ctl_t  ctl,
	input  logic [QLW-1:0]         load_idx,
	input  edsim_pkg::edsim_wave_t wave_in,
	output edsim_pkg::edsim_wave_t wave_out
);

	edsim_pkg::edsim_wave_t wave [MAX_QUERY+1];

	assign wave[0] = wave_in;

	for (genvar i = 0; i < MAX_QUERY; i++) begin : g_cell
		edsim_pkg::edsim_ctl_t cell_ctl;

		always_comb begin
			cell_ctl      = ctl;
			cell_ctl.load = ctl.load && (load_idx == QLW'(i));
		end

		edsim_cell #(
			.INDEX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (cell_ctl),
			.wave_in  (wave[i]),
			.wave_out (wave[i+1])
		);
	end

	assign wave_out = wave[MAX_QUERY];

endmodule

// File: hw/rtl/edsim_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edsim_div
// Restoring divider, one quotient bit a cycle: floor(num * 2^16 / den), num < den.
// ----------------------------------------------------------------------------
module edsim_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [edsim_pkg::COST_W-1:0] num,
	input  logic [edsim_pkg::COST_W-1:0] den,
	output logic                         busy,
	output logic                         done,
	output logic [edsim_pkg::COST_W-1:0] quo
);

	logic [edsim_pkg::COST_W:0]      rem_q;
	logic [edsim_pkg::COST_W-1:0]    den_q;
	logic [edsim_pkg::COST_W-1:0]    quo_q;
	logic [edsim_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                            busy_q;
	logic                            done_q;

	logic [edsim_pkg::COST_W:0] rem2;
	logic                       fits;

	always_comb begin
		rem2 = {rem_q[edsim_pkg::COST_W-1:0], 1'b0};
		fits = rem2 >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= edsim_pkg::DIV_CNT_W'(edsim_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == edsim_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (rem2 - {1'b0, den_q}) : rem2;
			quo_q <= {quo_q[edsim_pkg::COST_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the edit-distance name similarity block.
// ----------------------------------------------------------------------------
// A queue of requests, filled phase by phase from the stimulus process, feeds
// a driver on the falling edge. Every transfer the block accepts also runs
// through a Levenshtein scorer kept in the bench. Each end-of-candidate
// request leaves one expected score behind. A monitor on the rising edge
// pops the oldest expected score and compares it with each result transfer.
// The threshold register changes over APB only between phases, once the
// block has drained. Each write is read back.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int          MAX_Q        = edsim_pkg::MAX_QUERY_DEF;
	localparam int          SETTLE_CYCLES = 2 * (MAX_Q + 20);
	localparam int          LONG_HOLD    = 400;
	localparam logic [2:0]  THRESH_ADDR  = {edsim_pkg::REG_MATCH_THRESHOLD, 2'b00};

	typedef struct packed {
		edsim_pkg::req_t             kind;
		logic [edsim_pkg::CHAR_W-1:0] code;
	} req_item_t;

	typedef struct packed {
		logic [15:0] distance;
		logic [16:0] similarity;
		logic        above;
		logic        trunc;
	} score_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = edsim_pkg::REQ_CLEAR;
	logic [7:0]  char_code = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] distance;
	logic [16:0] similarity;
	logic        above_threshold;
	logic        truncated;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	edit_distance_name_similarity dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.req_type        (req_type),
		.char_code       (char_code),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.distance        (distance),
		.similarity      (similarity),
		.above_threshold (above_threshold),
		.truncated       (truncated),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// bench state
	// ------------------------------------------------------------------
	req_item_t   req_fifo[$];       // requests still to be offered
	score_t      pending_scores[$]; // scores owed by the block, oldest first
	logic [7:0]  stim_query[$];     // query as the generator last built it

	bit          idle_en = 1'b0;    // random gaps and stalls allowed
	bit          in_fire = 1'b0;    // request transfer at the last rising edge
	int          send_gap = 0;
	int          stall_left = 0;
	int          hold_left = 0;
	int          hold_asks = 0;
	int          hold_served = 0;

	int          errors = 0;
	int          n_accepted = 0;
	int          n_scores = 0;
	int          n_writes = 0;
	int unsigned longest_cand = 0;

	// scorer state: mirrors what the row of cells should hold
	logic [7:0]  q_chars[MAX_Q];
	int unsigned row_cost[MAX_Q];
	int unsigned q_len = 0;
	int unsigned c_len = 0;
	bit          q_overflow = 1'b0;
	logic [16:0] thresh_model = edsim_pkg::THRESH_RESET;

	function automatic logic [7:0] lower_ascii(input logic [7:0] c);
		if (c >= "A" && c <= "Z") begin
			return c + 8'd32;
		end
		return c;
	endfunction

	// reload the cost row and forget the candidate in progress
	task automatic restart_row();
		for (int i = 0; i < MAX_Q; i++) begin
			row_cost[i] = i + 1;
		end
		c_len = 0;
	endtask

	task automatic levenshtein_step(input edsim_pkg::req_t kind, input logic [7:0] raw);
		logic [7:0]  c;
		int unsigned diag, left, up, sub, v, max_len, edit_dist;
		longint unsigned num;
		score_t      s;
		c = lower_ascii(raw);
		case (kind)
			edsim_pkg::REQ_CLEAR: begin
				q_len = 0;
				q_overflow = 1'b0;
				restart_row();
			end
			edsim_pkg::REQ_APPEND: begin
				if (q_len < MAX_Q) begin
					q_chars[q_len] = c;
					q_len++;
				end else begin
					q_overflow = 1'b1;
				end
				restart_row();
			end
			edsim_pkg::REQ_CHAR: begin
				if (c_len < 32'(edsim_pkg::CAND_MAX)) begin
					diag = c_len;
					left = c_len + 1;
					for (int i = 0; i < q_len; i++) begin
						up  = row_cost[i];
						sub = diag + ((q_chars[i] == c) ? 0 : 1);
						v   = (up + 1 < left + 1) ? up + 1 : left + 1;
						v   = (sub < v) ? sub : v;
						row_cost[i] = v & 32'hFFFF;
						diag = up;
						left = v;
					end
					c_len++;
					if (c_len > longest_cand) begin
						longest_cand = c_len;
					end
				end
			end
			default: begin
				if (q_len == 0) begin
					edit_dist = c_len;
					s.similarity = (c_len == 0) ? edsim_pkg::Q16_ONE : 17'd0;
				end else if (c_len == 0) begin
					edit_dist = q_len;
					s.similarity = 17'd0;
				end else begin
					edit_dist = row_cost[q_len - 1];
					max_len = (q_len > c_len) ? q_len : c_len;
					if (edit_dist > max_len) begin
						edit_dist = max_len;
					end
					num = longint'(max_len - edit_dist) * 65536;
					s.similarity = 17'(num / max_len);
				end
				s.distance = 16'(edit_dist);
				s.above = (s.similarity > thresh_model);
				s.trunc = q_overflow || (c_len >= 32'(edsim_pkg::CAND_MAX));
				pending_scores.insert(pending_scores.size(), s);
				restart_row();
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// request driver: new payload only after a transfer or while idle
	// ------------------------------------------------------------------
	always @(negedge clk) begin : req_driver
		req_item_t item;
		if (!in_valid || in_fire) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (req_fifo.size() != 0 && idle_en && $urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(0, 2);
				in_valid <= 1'b0;
			end else if (req_fifo.size() != 0) begin
				item = req_fifo.pop_front();
				in_valid  <= 1'b1;
				req_type  <= item.kind;
				char_code <= item.code;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// result stall: short random bursts, plus one long hold when asked
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_asks != hold_served) begin
			hold_served = hold_asks;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// monitor: check result transfers, score request transfers
	// ------------------------------------------------------------------
	always @(posedge clk) begin : score_monitor
		score_t got, want;
		in_fire <= in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			got.distance   = distance;
			got.similarity = similarity;
			got.above      = above_threshold;
			got.trunc      = truncated;
			if (pending_scores.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: dist %0d sim %0d above %0b trunc %0b",
					$time, got.distance, got.similarity, got.above, got.trunc);
			end else begin
				want = pending_scores.pop_front();
				n_scores++;
				if (got !== want) begin
					errors++;
					$display("%0t: score mismatch: expected dist %0d sim %0d above %0b trunc %0b",
						$time, want.distance, want.similarity, want.above, want.trunc);
					$display("%0t:                 actual dist %0d sim %0d above %0b trunc %0b",
						$time, got.distance, got.similarity, got.above, got.trunc);
				end
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			n_accepted++;
			levenshtein_step(edsim_pkg::req_t'(req_type), char_code);
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_req(input edsim_pkg::req_t kind, input logic [7:0] code);
		req_item_t item;
		item.kind = kind;
		item.code = code;
		req_fifo.insert(req_fifo.size(), item);
	endtask

	// a small alphabet so matches are common, otherwise any byte
	function automatic logic [7:0] pick_char();
		logic [7:0] small_set[5] = '{"a", "b", "c", "A", "B"};
		if ($urandom_range(0, 9) < 6) begin
			return small_set[$urandom_range(0, 4)];
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// one APB transfer; a read is checked against the bench's copy
	task automatic apb_xfer(input bit wr, input logic [16:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= THRESH_ADDR;
		pwdata  <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (wr) begin
			thresh_model = value;
			n_writes++;
		end else if (prdata[16:0] !== thresh_model) begin
			errors++;
			$display("%0t: threshold readback: expected %0d actual %0d",
				$time, thresh_model, prdata[16:0]);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_threshold(input logic [16:0] value);
		apb_xfer(1'b1, value);
		apb_xfer(1'b0, 17'd0);
	endtask

	// all requests taken, all scores back, then let the row settle
	task automatic drain();
		while (req_fifo.size() != 0 || in_valid) @(posedge clk);
		while (pending_scores.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly well-formed queries and candidates, some noise and abandoned ones
	task automatic gen_traffic(input int n_items);
		int         made, len, r, i;
		logic [7:0] c;
		made = 0;
		while (made < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				push_req(edsim_pkg::req_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
				made++;
			end else if (r < 22 || (stim_query.size() == 0 && r < 50)) begin
				push_req(edsim_pkg::REQ_CLEAR, 8'($urandom_range(0, 255)));
				stim_query.delete();
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 10);
				repeat (len) begin
					c = pick_char();
					stim_query.insert(stim_query.size(), c);
					push_req(edsim_pkg::REQ_APPEND, c);
				end
				made += len + 1;
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 12);
				for (i = 0; i < len; i++) begin
					// an append mid-candidate abandons it
					if ($urandom_range(0, 39) == 0) begin
						c = pick_char();
						stim_query.insert(stim_query.size(), c);
						push_req(edsim_pkg::REQ_APPEND, c);
						made++;
					end
					if (i < stim_query.size() && $urandom_range(0, 3) != 0) begin
						c = stim_query[i] ^ (($urandom_range(0, 3) == 0) ? 8'h20 : 8'h00);
					end else begin
						c = pick_char();
					end
					push_req(edsim_pkg::REQ_CHAR, c);
					made++;
				end
				push_req(edsim_pkg::REQ_END, 8'($urandom_range(0, 255)));
				made++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// phases
	// ------------------------------------------------------------------
	initial begin
		restart_row();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// threshold should come out of reset at about 0.6
		apb_xfer(1'b0, 17'd0);
		idle_en = 1'b1;

		// directed: empty strings, case folding, byte extremes, append mid-candidate
		push_req(edsim_pkg::REQ_END, 8'h00);              // both empty
		push_req(edsim_pkg::REQ_CHAR, "A");
		push_req(edsim_pkg::REQ_CHAR, 8'hFF);
		push_req(edsim_pkg::REQ_END, 8'hFF);              // query empty only
		push_req(edsim_pkg::REQ_CLEAR, 8'hFF);
		push_req(edsim_pkg::REQ_APPEND, "C");
		push_req(edsim_pkg::REQ_APPEND, "a");
		push_req(edsim_pkg::REQ_APPEND, "T");
		push_req(edsim_pkg::REQ_END, 8'h00);              // candidate empty only
		push_req(edsim_pkg::REQ_CHAR, "c");
		push_req(edsim_pkg::REQ_CHAR, "u");
		push_req(edsim_pkg::REQ_CHAR, "t");
		push_req(edsim_pkg::REQ_CHAR, "s");
		push_req(edsim_pkg::REQ_END, 8'h00);
		push_req(edsim_pkg::REQ_CHAR, "@");               // just outside A-Z
		push_req(edsim_pkg::REQ_CHAR, "[");
		push_req(edsim_pkg::REQ_CHAR, "Z");
		push_req(edsim_pkg::REQ_CHAR, 8'h00);
		push_req(edsim_pkg::REQ_END, 8'h00);
		push_req(edsim_pkg::REQ_CHAR, "c");
		push_req(edsim_pkg::REQ_APPEND, "Z");             // candidate abandoned
		push_req(edsim_pkg::REQ_CHAR, "C");
		push_req(edsim_pkg::REQ_CHAR, "a");
		push_req(edsim_pkg::REQ_CHAR, "t");
		push_req(edsim_pkg::REQ_CHAR, "z");
		push_req(edsim_pkg::REQ_END, 8'h00);
		drain();

		// full query: two characters past the row are dropped and flagged
		set_threshold(17'd65535);
		push_req(edsim_pkg::REQ_CLEAR, 8'h00);
		stim_query.delete();
		repeat (MAX_Q + 2) begin
			stim_query.insert(stim_query.size(), 8'($urandom_range("a", "z")));
			push_req(edsim_pkg::REQ_APPEND, stim_query[$]);
		end
		for (int i = 0; i < MAX_Q; i++) begin
			push_req(edsim_pkg::REQ_CHAR, stim_query[i]);
		end
		push_req(edsim_pkg::REQ_END, 8'h00);
		for (int i = 0; i < MAX_Q / 2; i++) begin
			push_req(edsim_pkg::REQ_CHAR, stim_query[i] ^ 8'h20);
		end
		push_req(edsim_pkg::REQ_END, 8'h00);
		push_req(edsim_pkg::REQ_CLEAR, 8'h00);            // clears the flag
		push_req(edsim_pkg::REQ_END, 8'h00);
		stim_query.delete();
		drain();

		// random traffic across thresholds, long output hold in the middle
		set_threshold(17'($urandom_range(20000, 60000)));
		gen_traffic(280);
		drain();

		set_threshold(17'd0);
		gen_traffic(280);
		@(posedge clk);
		hold_asks++;
		drain();

		set_threshold(edsim_pkg::Q16_ONE);
		gen_traffic(280);
		drain();

		// threshold above one: the flag can never be set
		set_threshold(17'h1FFFF);
		gen_traffic(280);
		drain();

		// closing stretch with no gaps or stalls
		idle_en = 1'b0;
		set_threshold(17'($urandom_range(0, 65536)));
		stim_query.delete();
		gen_traffic(280);
		drain();

		$display("Covered %0d requests and %0d scores over %0d threshold writes,",
			n_accepted, n_scores, n_writes);
		$display("with candidates up to %0d characters and a %0d-cycle output hold.",
			longest_cand, LONG_HOLD);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("Timed out with %0d requests queued and %0d scores owed.",
			req_fifo.size(), pending_scores.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
